FILE: rtl/gmf_pkg.sv
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared types and constants of the 3x3 geometric mean filter.
// ----------------------------------------------------------------------------
package gmf_pkg;

  localparam int GMF_MAX_WIDTH = 1024;
  localparam int PIX_W         = 8;
  localparam int IMG_W_BITS    = 11;
  localparam int IMG_H_BITS    = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 12;
  localparam int PROD_W        = 72;
  localparam int WIN_N         = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 12'd1024;

  typedef struct packed {
    logic [WIN_N-1:0][PIX_W-1:0] pix;
    logic                        last;
  } win_item_t;

endpackage

FILE: rtl/gmf_front.sv
// ----------------------------------------------------------------------------
// gmf_front
// Line stores, 3x3 window and raster counters; pushes interior windows.
// ----------------------------------------------------------------------------
module gmf_front
  import gmf_pkg::*;
#(
  parameter int MAX_WIDTH = GMF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  push,
  output win_item_t             push_item,
  input  logic                  push_ready
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ? $clog2(MAX_WIDTH + 1) : IMG_W_BITS;

  logic [IMG_W_BITS-1:0] w_cfg_r;
  logic [IMG_H_BITS-1:0] h_cfg_r;
  logic [CW-1:0]         col_r;
  logic [IMG_H_BITS-1:0] row_r;
  logic                  rd_ok_r;
  logic [2*PIX_W-1:0]    rd_r;
  logic [2*PIX_W-1:0]    mem [MAX_WIDTH];
  logic [WIN_N-1:0][PIX_W-1:0] win_r;
  logic [WIN_N-1:0][PIX_W-1:0] win_nxt;

  logic [WW-1:0]         w_ext;
  logic [WW-1:0]         w_eff;
  logic [CW-1:0]         w_last;
  logic [IMG_H_BITS-1:0] h_last;
  logic [CW-1:0]         c_sat;
  logic [IMG_H_BITS-1:0] r_sat;
  logic                  acc;
  logic                  emit;

  always_comb begin
    w_ext = WW'(w_cfg_r);
    if (w_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_last = CW'(w_eff - WW'(1));
    h_last = (h_cfg_r < IMG_H_BITS'(3)) ? IMG_H_BITS'(2) : h_cfg_r - IMG_H_BITS'(1);
    c_sat  = (col_r > w_last) ? w_last : col_r;
    r_sat  = (row_r > h_last) ? h_last : row_r;
  end

  assign in_ready = rd_ok_r && push_ready;
  assign acc      = in_valid && in_ready;
  assign emit     = (r_sat >= IMG_H_BITS'(2)) && (c_sat >= CW'(2));

  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]   = win_r[k*3+1];
      win_nxt[k*3+1] = win_r[k*3+2];
    end
    win_nxt[2] = rd_r[2*PIX_W-1:PIX_W];
    win_nxt[5] = rd_r[PIX_W-1:0];
    win_nxt[8] = in_pixel;
  end

  assign push           = acc && emit;
  assign push_item.pix  = win_nxt;
  assign push_item.last = (r_sat == h_last) && (c_sat == w_last);

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[c_sat] <= {rd_r[PIX_W-1:0], in_pixel};
    end
    rd_r <= mem[c_sat];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cfg_r <= IMAGE_WIDTH_RST;
      h_cfg_r <= IMAGE_HEIGHT_RST;
      col_r   <= '0;
      row_r   <= '0;
      rd_ok_r <= 1'b0;
      win_r   <= '0;
    end else begin
      rd_ok_r <= !(acc || cfg_valid);
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  w_cfg_r <= cfg_data[IMG_W_BITS-1:0];
          REG_IMAGE_HEIGHT: h_cfg_r <= cfg_data[IMG_H_BITS-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        win_r <= win_nxt;
        if (c_sat == w_last) begin
          col_r <= '0;
          row_r <= (r_sat == h_last) ? '0 : r_sat + IMG_H_BITS'(1);
        end else begin
          col_r <= c_sat + CW'(1);
          row_r <= r_sat;
        end
      end
    end
  end

endmodule

FILE: rtl/gmf_queue.sv
// ----------------------------------------------------------------------------
// gmf_queue
// Two-entry window queue between the front and the root unit.
// ----------------------------------------------------------------------------
module gmf_queue
  import gmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  win_item_t push_item,
  output logic      push_ready,
  input  logic      pop,
  output win_item_t pop_item,
  output logic      pop_valid
);

  win_item_t  ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/gmf_root.sv
// ----------------------------------------------------------------------------
// gmf_root
// Window product and bitwise ninth-root search on one shared multiplier.
// ----------------------------------------------------------------------------
module gmf_root
  import gmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  win_item_t        pop_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_filtered_value,
  output logic             out_last_of_image
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PROD = 3'd1;
  localparam logic [2:0] B_POW  = 3'd2;
  localparam logic [2:0] B_CMP  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]                  st_r;
  logic [WIN_N-1:0][PIX_W-1:0] pix_r;
  logic                        last_r;
  logic [PROD_W-1:0]           q_r;
  logic [PROD_W-1:0]           p_r;
  logic [PIX_W-1:0]            y_r;
  logic [2:0]                  bit_r;
  logic [3:0]                  cnt_r;
  logic                        out_valid_r;
  logic [PIX_W-1:0]            out_val_r;
  logic                        out_last_r;

  logic [PIX_W-1:0]  cur;
  logic [PIX_W-1:0]  fac;
  logic [PIX_W-1:0]  trial;
  logic [PROD_W-1:0] mul_a;
  logic [PIX_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              load;

  assign cur   = pix_r[cnt_r];
  assign fac   = (cur == '0) ? PIX_W'(255) : cur;
  assign trial = y_r | (PIX_W'(1) << bit_r);
  assign mul_a = (st_r == B_PROD) ? q_r : p_r;
  assign mul_b = (st_r == B_PROD) ? fac : trial;
  assign mul_p = mul_a * PROD_W'(mul_b);

  assign pop  = (st_r == B_IDLE) && pop_valid;
  assign load = (st_r == B_OUT) && (!out_valid_r || out_ready);

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_val_r;
  assign out_last_of_image  = out_last_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r  <= pop_item.pix;
      last_r <= pop_item.last;
    end
    if (load) begin
      out_val_r  <= y_r;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= '0;
      p_r         <= '0;
      y_r         <= '0;
      bit_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: begin
          if (pop_valid) begin
            q_r   <= PROD_W'(1);
            cnt_r <= '0;
            st_r  <= B_PROD;
          end
        end
        B_PROD: begin
          q_r <= mul_p;
          if (cnt_r == 4'(WIN_N - 1)) begin
            bit_r <= 3'd7;
            y_r   <= '0;
            p_r   <= PROD_W'(1);
            cnt_r <= '0;
            st_r  <= B_POW;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        B_POW: begin
          p_r <= mul_p;
          if (cnt_r == 4'(WIN_N - 1)) begin
            st_r <= B_CMP;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        B_CMP: begin
          if (p_r <= q_r) begin
            y_r <= trial;
          end
          p_r   <= PROD_W'(1);
          cnt_r <= '0;
          if (bit_r == 3'd0) begin
            st_r <= B_OUT;
          end else begin
            bit_r <= bit_r - 3'd1;
            st_r  <= B_POW;
          end
        end
        B_OUT: begin
          if (load) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/geometric_mean_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// geometric_mean_filter_3x3_top
// 3x3 geometric mean filter over a raster stream of 8-bit grey pixels.
//
// Pixels enter on in_* in raster order; one transaction per pixel. Results
// leave on out_* only for interior pixels, the last one of an image flagged
// by out_last_of_image. Image size is set on cfg_* (index 0 width, 1 height);
// the user must set it only while the block is idle, which the block does
// not enforce; cfg_ready is always high. For each pixel the front reads the
// line store, then writes it and shifts the window; it takes no pixel during
// the read. Windows go into a 2-entry queue. The root unit uses one 72x8
// multiplier: it forms the window product, then settles the 8 result bits
// from the top, each by comparing the trial value's ninth power with the
// product, then loads the output. It pops a window only when idle.
// Reset clears counters, window and control; line store content is unset.
// When the receiver stalls the result holds in the output register, the root
// unit finishes its next window and waits, and the front stops once the
// queue is full.
// ----------------------------------------------------------------------------
module geometric_mean_filter_3x3_top
  import gmf_pkg::*;
#(
  parameter int MAX_WIDTH = GMF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_filtered_value,
  output logic                  out_last_of_image,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      push;
  logic      push_ready;
  win_item_t push_item;
  logic      pop;
  logic      pop_valid;
  win_item_t pop_item;

  assign cfg_ready = 1'b1;

  gmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  gmf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid)
  );

  gmf_root u_root (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_item           (pop_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_last_of_image  (out_last_of_image)
  );

endmodule

FILE: rtl/gmf_checker.sv
// ----------------------------------------------------------------------------
// gmf_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module gmf_checker
  import gmf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_filtered_value,
  input logic             out_last_of_image
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_value)
      && $stable(out_last_of_image))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channels active after reset");

  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken before line store reread");

endmodule

bind geometric_mean_filter_3x3_top gmf_checker u_gmf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_value (out_filtered_value),
  .out_last_of_image  (out_last_of_image)
);

FILE: tb/geometric_mean_filter_3x3_checker.sv
// ----------------------------------------------------------------------------
// geometric_mean_filter_3x3_checker
// Watches the pixel, result and register channels of the 3x3 geometric mean
// filter. It keeps its own line stores, window and position counters, works
// out the integer ninth root of each completed window and compares the
// results in order.
// ----------------------------------------------------------------------------
module geometric_mean_filter_3x3_checker
  import gmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      out_filtered_value,
  input  logic                  out_last_of_image,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             last;
  } filt_result_t;

  filt_result_t           mean_q[$];
  logic [PIX_W-1:0]       row_store[2][GMF_MAX_WIDTH];
  logic [PIX_W-1:0]       win[WIN_N];
  int unsigned            col_pos;
  int unsigned            row_pos;
  logic [IMG_W_BITS-1:0]  width_reg;
  logic [IMG_H_BITS-1:0]  height_reg;

  function automatic logic [PIX_W-1:0] window_mean(input logic [PIX_W-1:0] px[WIN_N]);
    logic [79:0] prod;
    logic [79:0] pw;
    int lo;
    int hi;
    int mid;
    prod = 80'd1;
    for (int k = 0; k < WIN_N; k++) begin
      prod = prod * ((px[k] == 0) ? 80'd255 : 80'(px[k]));
    end
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      pw = 80'd1;
      for (int k = 0; k < WIN_N; k++) pw = pw * 80'(mid);
      if (pw <= prod) lo = mid;
      else hi = mid - 1;
    end
    return PIX_W'(lo);
  endfunction

  task automatic accept_pixel(input logic [PIX_W-1:0] p);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    filt_result_t res;
    w = width_reg;
    h = height_reg;
    if (w < 3) w = 3;
    if (w > GMF_MAX_WIDTH) w = GMF_MAX_WIDTH;
    if (h < 3) h = 3;
    if (col_pos >= w) col_pos = w - 1;
    if (row_pos >= h) row_pos = h - 1;
    c = col_pos;
    r = row_pos;
    top_px = row_store[1][c];
    mid_px = row_store[0][c];
    row_store[1][c] = mid_px;
    row_store[0][c] = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = p;
    if (r >= 2 && c >= 2) begin
      res.mean = window_mean(win);
      res.last = (r == h - 1 && c == w - 1);
      mean_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < GMF_MAX_WIDTH; i++) begin
      row_store[0][i] = '0;
      row_store[1][i] = '0;
    end
  end

  always @(posedge clk) begin
    filt_result_t want;
    if (!rst_n) begin
      mean_q.delete();
      for (int k = 0; k < WIN_N; k++) win[k] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[IMG_W_BITS-1:0];
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data[IMG_H_BITS-1:0];
      end
      if (in_valid && in_ready) accept_pixel(in_pixel);
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: value %0d last %0b",
                     out_filtered_value, out_last_of_image);
        end else begin
          want = mean_q.pop_front();
          if (want.mean !== out_filtered_value || want.last !== out_last_of_image) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected value %0d last %0b, got value %0d last %0b",
                       want.mean, want.last, out_filtered_value, out_last_of_image);
          end
        end
      end
    end
    pending = mean_q.size();
  end

endmodule

FILE: tb/geometric_mean_filter_3x3_top_test.sv
// ----------------------------------------------------------------------------
// geometric_mean_filter_3x3_top_test
// Drives whole images through the 3x3 geometric mean filter: directed 3x3
// images, one 8x8 image, then many small random images. Image size is
// changed only while the block is idle. Both channels idle at random save in
// the last random third; the receiver once holds off for a long stretch.
// ----------------------------------------------------------------------------
module geometric_mean_filter_3x3_top_test;
  import gmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_PIXELS = 1450;
  localparam int DRAIN_CYCLES = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      out_filtered_value;
  logic                  out_last_of_image;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    cycle_count;
  int                    results_seen;
  int                    hold_left;
  bit                    hold_done;

  geometric_mean_filter_3x3_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_filtered_value(out_filtered_value), .out_last_of_image(out_last_of_image),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  geometric_mean_filter_3x3_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_filtered_value(out_filtered_value), .out_last_of_image(out_last_of_image),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // hold off once, long enough to fill the block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) results_seen <= results_seen + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen == 4) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int style);
    case (style)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
      default: begin
        case ($urandom_range(7))
          0: return 8'd0;
          1: return 8'd255;
          2: return PIX_W'($urandom_range(1, 4));
          default: return PIX_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic run_image(input int w, input int h, input int style, inout int sent);
    int ew;
    int eh;
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    ew = (w < 3) ? 3 : ((w > GMF_MAX_WIDTH) ? GMF_MAX_WIDTH : w);
    eh = (h < 3) ? 3 : h;
    for (int i = 0; i < ew * eh; i++) begin
      send_pixel(pick_pixel(style));
      sent++;
    end
  endtask

  initial begin
    int sent;
    int w;
    int h;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 80;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_image(3, 3, 0, sent);
    run_image(3, 3, 1, sent);
    run_image(3, 3, 3, sent);
    run_image(8, 8, 4, sent);

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if (sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 80;
      end else if (sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
      h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      run_image(w, h, ($urandom_range(15) == 0) ? 2 : 4, sent);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gmf_pkg.sv
rtl/gmf_front.sv
rtl/gmf_queue.sv
rtl/gmf_root.sv
rtl/geometric_mean_filter_3x3_top.sv
rtl/gmf_checker.sv
tb/geometric_mean_filter_3x3_checker.sv
tb/geometric_mean_filter_3x3_top_test.sv
